### rtl/kn_pkg.sv
// Shared types, constants and fixed-point helpers for the Kerr-Newman metric evaluator.
package kn_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int OUT_BITS   = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
  localparam int N_QUOT     = 5;
  localparam int DIV_STEPS  = 32;
  localparam int FRONT_LAT  = 11;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int PIPE_LAT   = FRONT_LAT + DIV_LAT;

  // signed Q.32 working word
  typedef logic signed [63:0] wq_t;

  localparam wq_t        WMAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam wq_t        ONE_Q32 = 64'sh0000_0001_0000_0000;
  localparam logic [32:0] QLIM   = (33'd1 << (OUT_BITS - 1)) - 33'd1;

  typedef enum logic [1:0] {
    CFG_MASS   = 2'd0,
    CFG_SPIN   = 2'd1,
    CFG_CHARGE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SIGMA_ZERO = 3'd1,
    ST_DELTA_ZERO = 3'd2,
    ST_POLE       = 3'd3,
    ST_SAT        = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [31:0] radius;
    logic signed [31:0] cos_theta;
  } kn_in_t;

  typedef struct packed {
    logic signed [31:0] g_tt;
    logic signed [31:0] g_tphi;
    logic signed [31:0] g_rr;
    logic signed [31:0] g_thth;
    logic signed [31:0] g_phiphi;
    logic [2:0]         status;
  } kn_out_t;

  typedef struct packed {
    logic sig_zero;
    logic del_zero;
    logic pole;
    logic sat;
  } kn_flags_t;

  // magnitude of a Q.32 word (never fed the most negative code)
  function automatic logic [63:0] mag(input wq_t v);
    mag = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // saturating add, {sat, sum}
  function automatic logic [64:0] wadd(input wq_t a, input wq_t b);
    logic signed [64:0] sum;
    sum = $signed({a[63], a}) + $signed({b[63], b});
    if (sum > $signed({1'b0, WMAX})) begin
      wadd = {1'b1, WMAX};
    end else if (sum < -$signed({1'b0, WMAX})) begin
      wadd = {1'b1, -WMAX};
    end else begin
      wadd = {1'b0, sum[63:0]};
    end
  endfunction

  function automatic logic [64:0] wsub(input wq_t a, input wq_t b);
    wsub = wadd(a, -b);
  endfunction

endpackage

### rtl/kerr_newman_metric_eval.sv
// Kerr-Newman metric evaluator, top level: config registers, pipeline control, result stage.
// Takes one point (r, cos theta) per cycle unless stalled and returns g_tt, g_tphi, g_rr,
// g_thth and g_phiphi in Q16.16 with a status code, one result per request, in order. The
// depth is set by the five pipelined restoring dividers that follow an 11-stage multiply/add
// front end, plus the result register. The whole pipe advances together;
// out_stall on a waiting result freezes it and shows up on in_stall in the same cycle.
// mass, spin and charge must be written only while no request is in flight.
module kerr_newman_metric_eval import kn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  kn_in_t      in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output kn_out_t     out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [30:0]        mass_r;
  logic signed [31:0] spin_r, charge_r;

  logic                en;
  logic [PIPE_LAT-1:0] vld_r;
  logic                out_valid_r;
  kn_out_t             out_data_r, out_nxt;

  wq_t         num [N_QUOT];
  wq_t         den [N_QUOT];
  kn_flags_t   flags;
  kn_flags_t   flg_r [0:DIV_LAT-1];
  logic [31:0] qv [N_QUOT];
  logic [N_QUOT-1:0] dsat;
  kn_flags_t   fl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r   <= 31'd65536;
      spin_r   <= '0;
      charge_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MASS:   mass_r   <= cfg_wdata[30:0];
        CFG_SPIN:   spin_r   <= cfg_wdata;
        CFG_CHARGE: charge_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  kn_front u_front (
    .clk, .en, .in_data,
    .mass(mass_r), .spin(spin_r), .charge(charge_r),
    .num, .den, .flags
  );

  for (genvar k = 0; k < N_QUOT; k++) begin : g_div
    kn_div u_div (.clk, .en, .n(num[k]), .d(den[k]), .q(qv[k]), .sat(dsat[k]));
  end

  // side flags ride alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      flg_r[0] <= flags;
      for (int i = 1; i < DIV_LAT; i++) begin
        flg_r[i] <= flg_r[i-1];
      end
    end
  end

  assign fl = flg_r[DIV_LAT-1];

  always_comb begin
    out_nxt.g_tt     = qv[0];
    out_nxt.g_tphi   = qv[1];
    out_nxt.g_rr     = qv[2];
    out_nxt.g_thth   = qv[3];
    out_nxt.g_phiphi = qv[4];
    out_nxt.status   = ST_OK;
    if (fl.sig_zero || fl.del_zero || fl.pole) begin
      out_nxt.g_tt     = '0;
      out_nxt.g_tphi   = '0;
      out_nxt.g_rr     = '0;
      out_nxt.g_thth   = '0;
      out_nxt.g_phiphi = '0;
    end
    if (fl.sig_zero) begin
      out_nxt.status = ST_SIGMA_ZERO;
    end else if (fl.del_zero) begin
      out_nxt.status = ST_DELTA_ZERO;
    end else if (fl.pole) begin
      out_nxt.status = ST_POLE;
    end else if (fl.sat || (|dsat)) begin
      out_nxt.status = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/kn_mul.sv
// Two-stage Q.32 multiplier: four 32x32 partial products, then round and saturate.
module kn_mul import kn_pkg::*; (
  input  logic clk,
  input  logic en,
  input  wq_t  x,
  input  wq_t  y,
  output wq_t  p,
  output logic sat
);

  logic [63:0]  ax, ay;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic         ng_r;
  logic [127:0] full;
  logic         ovf;
  wq_t          mv;
  wq_t          p_r;
  logic         sat_r;

  assign ax = mag(x);
  assign ay = mag(y);

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ax[31:0]  * ay[31:0];
      lh_r <= ax[31:0]  * ay[63:32];
      hl_r <= ax[63:32] * ay[31:0];
      hh_r <= ax[63:32] * ay[63:32];
      ng_r <= x[63] ^ y[63];
    end
  end

  // exact product plus half an LSB of Q.32
  assign full = {64'b0, ll_r} + {32'b0, lh_r, 32'b0} + {32'b0, hl_r, 32'b0}
              + {hh_r, 64'b0} + 128'h8000_0000;
  assign ovf  = |full[127:95];
  assign mv   = ovf ? WMAX : wq_t'({1'b0, full[94:32]});

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= ng_r ? -mv : mv;
      sat_r <= ovf;
    end
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule

### rtl/kn_div.sv
// Pipelined restoring divider: Q.32 over Q.32 to rounded, saturated Q16.16, one bit a stage.
module kn_div import kn_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  wq_t         n,
  input  wq_t         d,
  output logic [31:0] q,
  output logic        sat
);

  logic [63:0] un, ud;
  logic [63:0] ud_r  [0:DIV_STEPS];
  logic [63:0] rem_r [0:DIV_STEPS];
  logic [31:0] lw_r  [0:DIV_STEPS];
  logic [31:0] qb_r  [0:DIV_STEPS];
  logic        ng_r  [0:DIV_STEPS];
  logic        big_r [0:DIV_STEPS];

  logic        rnd;
  logic [32:0] q1, limit, qm, qs_nxt;
  logic        ovf;
  logic [31:0] q_r;
  logic        sat_r;

  assign un = mag(n);
  assign ud = mag(d);

  // quotient of 2^32 or more always saturates; otherwise un>>16 < ud starts the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      ud_r[0]  <= ud;
      rem_r[0] <= {16'b0, un[63:16]};
      lw_r[0]  <= {un[15:0], 16'b0};
      qb_r[0]  <= '0;
      ng_r[0]  <= n[63] ^ d[63];
      big_r[0] <= {16'b0, un} >= {ud, 16'b0};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [64:0] rem2;
    logic        ge;
    logic [64:0] rem_nxt;

    assign rem2    = {rem_r[k], lw_r[k][31]};
    assign ge      = rem2 >= {1'b0, ud_r[k]};
    assign rem_nxt = ge ? rem2 - {1'b0, ud_r[k]} : rem2;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt[63:0];
        lw_r[k+1]  <= {lw_r[k][30:0], 1'b0};
        qb_r[k+1]  <= {qb_r[k][30:0], ge};
        ud_r[k+1]  <= ud_r[k];
        ng_r[k+1]  <= ng_r[k];
        big_r[k+1] <= big_r[k];
      end
    end
  end

  // round half away from zero, then clamp to the output range
  assign rnd    = rem_r[DIV_STEPS] >= (ud_r[DIV_STEPS] - rem_r[DIV_STEPS]);
  assign q1     = {1'b0, qb_r[DIV_STEPS]} + {32'b0, rnd};
  assign limit  = QLIM + {32'b0, ng_r[DIV_STEPS]};
  assign ovf    = big_r[DIV_STEPS] | (q1 > limit);
  assign qm     = ovf ? limit : q1;
  assign qs_nxt = ng_r[DIV_STEPS] ? -qm : qm;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= qs_nxt[31:0];
      sat_r <= ovf;
    end
  end

  assign q   = q_r;
  assign sat = sat_r;

endmodule

### rtl/kn_front.sv
// Metric front end: Sigma, Delta and the five numerator/denominator pairs, eleven stages.
module kn_front import kn_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  kn_in_t             in_data,
  input  logic [30:0]        mass,
  input  logic signed [31:0] spin,
  input  logic signed [31:0] charge,
  output wq_t                num [N_QUOT],
  output wq_t                den [N_QUOT],
  output kn_flags_t          flags
);

  wq_t a_w, q_w, m_w;
  wq_t rr0_r, x0_r;

  wq_t  r2_m, a2_m, q2_m, c2_m, mr_m, a2c2_m, as_m, a2s_m, rara_m, ase_m, a2sd_m, n4_m;
  logic r2_s, a2_s, q2_s, c2_s, mr_s, a2c2_s, as_s, a2s_s, rara_s, ase_s, a2sd_s, n4_s;

  logic [64:0] s3_nxt, mr3_nxt, e4_nxt, ra4_nxt, sig5_nxt, del5_nxt, sge6_nxt, t8_nxt;

  wq_t  s3_r, mr2_3_r, r2_3_r, a2_3_r, q2_3_r;
  wq_t  e4_r, ra4_r, r2_4_r, s4_r;
  wq_t  sig5_r, del5_r, e5_r, s5_r, ra5_r;
  wq_t  sge6_r, sig6_r, del6_r, s6_r;
  wq_t  n0_7_r, sig7_r, del7_r, s7_r;
  wq_t  t8_r, ase8_r, n0_8_r, sig8_r, del8_r, s8_r;
  wq_t  ase9_r, n0_9_r, sig9_r, del9_r, s9_r;
  wq_t  ase10_r, n0_10_r, sig10_r, del10_r, s10_r;
  logic sat3_r, sat4_r, sat5_r, sat6_r, sat7_r, sat8_r, sat9_r, sat10_r;

  assign a_w = {{16{spin[31]}}, spin, 16'b0};
  assign q_w = {{16{charge[31]}}, charge, 16'b0};
  assign m_w = {17'b0, mass, 16'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      rr0_r <= {{16{in_data.radius[31]}}, in_data.radius, 16'b0};
      x0_r  <= {{30{in_data.cos_theta[31]}}, in_data.cos_theta, 2'b0};
    end
  end

  kn_mul u_r2 (.clk, .en, .x(rr0_r), .y(rr0_r), .p(r2_m), .sat(r2_s));
  kn_mul u_a2 (.clk, .en, .x(a_w),   .y(a_w),   .p(a2_m), .sat(a2_s));
  kn_mul u_q2 (.clk, .en, .x(q_w),   .y(q_w),   .p(q2_m), .sat(q2_s));
  kn_mul u_c2 (.clk, .en, .x(x0_r),  .y(x0_r),  .p(c2_m), .sat(c2_s));
  kn_mul u_mr (.clk, .en, .x(m_w),   .y(rr0_r), .p(mr_m), .sat(mr_s));

  assign s3_nxt  = wsub(ONE_Q32, c2_m);
  assign mr3_nxt = wadd(mr_m, mr_m);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r    <= s3_nxt[63:0];
      mr2_3_r <= mr3_nxt[63:0];
      r2_3_r  <= r2_m;
      a2_3_r  <= a2_m;
      q2_3_r  <= q2_m;
      sat3_r  <= r2_s | a2_s | q2_s | c2_s | mr_s | s3_nxt[64] | mr3_nxt[64];
    end
  end

  kn_mul u_a2c2 (.clk, .en, .x(a2_m),   .y(c2_m), .p(a2c2_m), .sat(a2c2_s));
  kn_mul u_as   (.clk, .en, .x(a_w),    .y(s3_r), .p(as_m),   .sat(as_s));
  kn_mul u_a2s  (.clk, .en, .x(a2_3_r), .y(s3_r), .p(a2s_m),  .sat(a2s_s));

  assign e4_nxt  = wsub(q2_3_r, mr2_3_r);
  assign ra4_nxt = wadd(r2_3_r, a2_3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      e4_r   <= e4_nxt[63:0];
      ra4_r  <= ra4_nxt[63:0];
      r2_4_r <= r2_3_r;
      s4_r   <= s3_r;
      sat4_r <= sat3_r | e4_nxt[64] | ra4_nxt[64];
    end
  end

  assign sig5_nxt = wadd(r2_4_r, a2c2_m);
  assign del5_nxt = wadd(ra4_r, e4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sig5_r <= sig5_nxt[63:0];
      del5_r <= del5_nxt[63:0];
      e5_r   <= e4_r;
      s5_r   <= s4_r;
      ra5_r  <= ra4_r;
      sat5_r <= sat4_r | a2c2_s | sig5_nxt[64] | del5_nxt[64];
    end
  end

  kn_mul u_rara (.clk, .en, .x(ra5_r), .y(ra5_r),  .p(rara_m), .sat(rara_s));
  kn_mul u_ase  (.clk, .en, .x(as_m),  .y(e5_r),   .p(ase_m),  .sat(ase_s));
  kn_mul u_a2sd (.clk, .en, .x(a2s_m), .y(del5_r), .p(a2sd_m), .sat(a2sd_s));

  assign sge6_nxt = wadd(sig5_r, e5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sge6_r <= sge6_nxt[63:0];
      sig6_r <= sig5_r;
      del6_r <= del5_r;
      s6_r   <= s5_r;
      sat6_r <= sat5_r | as_s | a2s_s | sge6_nxt[64];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_7_r <= -sge6_r;
      sig7_r <= sig6_r;
      del7_r <= del6_r;
      s7_r   <= s6_r;
      sat7_r <= sat6_r;
    end
  end

  assign t8_nxt = wsub(rara_m, a2sd_m);

  always_ff @(posedge clk) begin
    if (en) begin
      t8_r   <= t8_nxt[63:0];
      ase8_r <= ase_m;
      n0_8_r <= n0_7_r;
      sig8_r <= sig7_r;
      del8_r <= del7_r;
      s8_r   <= s7_r;
      sat8_r <= sat7_r | rara_s | ase_s | a2sd_s | t8_nxt[64];
    end
  end

  kn_mul u_n4 (.clk, .en, .x(s8_r), .y(t8_r), .p(n4_m), .sat(n4_s));

  always_ff @(posedge clk) begin
    if (en) begin
      ase9_r  <= ase8_r;
      n0_9_r  <= n0_8_r;
      sig9_r  <= sig8_r;
      del9_r  <= del8_r;
      s9_r    <= s8_r;
      sat9_r  <= sat8_r;
      ase10_r <= ase9_r;
      n0_10_r <= n0_9_r;
      sig10_r <= sig9_r;
      del10_r <= del9_r;
      s10_r   <= s9_r;
      sat10_r <= sat9_r;
    end
  end

  assign num[0] = n0_10_r;
  assign num[1] = ase10_r;
  assign num[2] = sig10_r;
  assign num[3] = sig10_r;
  assign num[4] = n4_m;
  assign den[0] = sig10_r;
  assign den[1] = sig10_r;
  assign den[2] = del10_r;
  assign den[3] = s10_r;
  assign den[4] = sig10_r;

  assign flags.sig_zero = (sig10_r == '0);
  assign flags.del_zero = (del10_r == '0);
  assign flags.pole     = (s10_r == '0);
  assign flags.sat      = sat10_r | n4_s;

endmodule

### rtl/kn_checker.sv
// Port-level checks for the Kerr-Newman metric evaluator, bound to the top level.
module kn_checker import kn_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input kn_in_t      in_data,
  input logic        out_valid,
  input logic        out_stall,
  input kn_out_t     out_data,
  input logic        cfg_wr_en,
  input logic [1:0]  cfg_index,
  input logic [31:0] cfg_wdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the held result");

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_SIGMA_ZERO || out_data.status == ST_DELTA_ZERO ||
                  out_data.status == ST_POLE)
    |-> out_data.g_tt == 0 && out_data.g_tphi == 0 && out_data.g_rr == 0 &&
        out_data.g_thth == 0 && out_data.g_phiphi == 0)
    else $error("components not cleared on zero divisor");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind kerr_newman_metric_eval kn_checker u_kn_checker (.*);
